// ===== rtl/dld_pkg.sv =====
`default_nettype none

package dld_pkg;

  localparam int FRACTION_BITS_DEF = 16;

  localparam int SAMPLE_W   = 8;
  localparam int FINE_W     = 24;
  localparam int FINE_FRAC  = 16;
  localparam int DECAY_W    = 17;
  localparam int TIME_W     = 13;
  localparam int CURVE_W    = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Widths of the gain products: decay*dt and the final gain in Q0.32.
  localparam int GAIN_PROD_W = DECAY_W + TIME_W;
  localparam int GAIN_W      = 29;

  localparam int HALF_SHIFT = 17;
  localparam int FULL_SHIFT = 16;
  localparam int Q32_SHIFT  = 32;

  localparam logic [DECAY_W-1:0] DECAY_MIN = 17'd655;
  localparam logic [DECAY_W-1:0] DECAY_MAX = 17'd65536;
  localparam logic [DECAY_W-1:0] DECAY_RST = 17'd39322;
  localparam logic [TIME_W-1:0]  TIME_MIN  = 13'd66;
  localparam logic [TIME_W-1:0]  TIME_MAX  = 13'd6554;
  localparam logic [TIME_W-1:0]  TIME_RST  = 13'd6554;

  typedef enum logic [CURVE_W-1:0] {
    CURVE_LIN  = 2'd0,
    CURVE_HALF = 2'd1,
    CURVE_FULL = 2'd2
  } curve_t;

  typedef enum logic [1:0] {
    REG_DECAY = 2'd0,
    REG_TIME  = 2'd1,
    REG_CURVE = 2'd2,
    REG_HOLD  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DECAY_W-1:0] decay_gain;
    logic [TIME_W-1:0]  time_step;
    curve_t             curve_mode;
    logic               hold_when_unchanged;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/dld_in_if.sv =====
`default_nettype none

interface dld_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [dld_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/dld_out_if.sv =====
`default_nettype none

interface dld_out_if;
  logic                          valid;
  logic                          ready;
  logic [dld_pkg::SAMPLE_W-1:0]  level_out;
  logic [dld_pkg::FINE_W-1:0]    level_fine;
  logic                          busy_res;

  modport source (output valid, output level_out, output level_fine, output busy_res,
                  input ready);
  modport sink   (input valid, input level_out, input level_fine, input busy_res,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dld_cfg_regs.sv =====
`default_nettype none

module dld_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dld_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [dld_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [dld_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output dld_pkg::cfg_t                          cfg
);

  dld_pkg::cfg_t                     cfg_r;
  dld_pkg::cfg_t                     cfg_nxt;
  dld_pkg::reg_idx_t                 reg_idx;
  logic [dld_pkg::DECAY_W-1:0]       decay_wr;
  logic [dld_pkg::TIME_W-1:0]        time_wr;
  logic [dld_pkg::CURVE_W-1:0]       curve_wr;
  logic                              wr_en;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = dld_pkg::reg_idx_t'(paddr[3:2]);
  assign decay_wr = pwdata[dld_pkg::DECAY_W-1:0];
  assign time_wr  = pwdata[dld_pkg::TIME_W-1:0];
  assign curve_wr = pwdata[dld_pkg::CURVE_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        dld_pkg::REG_DECAY: begin
          if (decay_wr < dld_pkg::DECAY_MIN) begin
            cfg_nxt.decay_gain = dld_pkg::DECAY_MIN;
          end else if (decay_wr > dld_pkg::DECAY_MAX) begin
            cfg_nxt.decay_gain = dld_pkg::DECAY_MAX;
          end else begin
            cfg_nxt.decay_gain = decay_wr;
          end
        end
        dld_pkg::REG_TIME: begin
          if (time_wr < dld_pkg::TIME_MIN) begin
            cfg_nxt.time_step = dld_pkg::TIME_MIN;
          end else if (time_wr > dld_pkg::TIME_MAX) begin
            cfg_nxt.time_step = dld_pkg::TIME_MAX;
          end else begin
            cfg_nxt.time_step = time_wr;
          end
        end
        dld_pkg::REG_CURVE: begin
          if (curve_wr > dld_pkg::CURVE_FULL) begin
            cfg_nxt.curve_mode = dld_pkg::CURVE_LIN;
          end else begin
            cfg_nxt.curve_mode = dld_pkg::curve_t'(curve_wr);
          end
        end
        dld_pkg::REG_HOLD: begin
          cfg_nxt.hold_when_unchanged = pwdata[0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_gain          <= dld_pkg::DECAY_RST;
      cfg_r.time_step           <= dld_pkg::TIME_RST;
      cfg_r.curve_mode          <= dld_pkg::CURVE_LIN;
      cfg_r.hold_when_unchanged <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      dld_pkg::REG_DECAY: prdata = dld_pkg::CFG_DATA_W'(cfg_r.decay_gain);
      dld_pkg::REG_TIME:  prdata = dld_pkg::CFG_DATA_W'(cfg_r.time_step);
      dld_pkg::REG_CURVE: prdata = dld_pkg::CFG_DATA_W'(cfg_r.curve_mode);
      dld_pkg::REG_HOLD:  prdata = dld_pkg::CFG_DATA_W'(cfg_r.hold_when_unchanged);
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/dld_serial_mult.sv =====
`default_nettype none

module dld_serial_mult #(
  parameter int MC_W = dld_pkg::GAIN_PROD_W,
  parameter int MP_W = dld_pkg::DECAY_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [MC_W-1:0]        mc_in,
  input  wire logic [MP_W-1:0]        mp_in,
  output logic                        done,
  output logic [MC_W+MP_W-1:0]        product
);

  localparam int ACC_W = MC_W + MP_W;

  logic              busy_r;
  logic [ACC_W-1:0]  mc_r;
  logic [MP_W-1:0]   mp_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  partial;

  // Two multiplier bits are consumed per cycle, least significant first.
  assign partial = (mp_r[0] ? mc_r : '0) + (mp_r[1] ? {mc_r[ACC_W-2:0], 1'b0} : '0);
  assign done    = busy_r && (mp_r == '0);
  assign product = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= ACC_W'(mc_in);
      mp_r  <= mp_in;
      acc_r <= '0;
    end else if (busy_r && (mp_r != '0)) begin
      acc_r <= acc_r + partial;
      mc_r  <= {mc_r[ACC_W-3:0], 2'b00};
      mp_r  <= {2'b00, mp_r[MP_W-1:2]};
    end
  end

`ifndef NO_ASSERTIONS
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (!busy_r || done))
    else $error("multiplier restarted in the middle of a product");
`endif

endmodule

`default_nettype wire

// ===== rtl/dld_ctrl.sv =====
`default_nettype none

module dld_ctrl #(
  parameter int FRACTION_BITS = dld_pkg::FRACTION_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dld_pkg::cfg_t cfg,
  dld_in_if.sink             in_ch,
  dld_out_if.source          out_ch
);

  localparam int F     = FRACTION_BITS;
  localparam int LW    = dld_pkg::SAMPLE_W + F;
  localparam int MC_W  = dld_pkg::GAIN_PROD_W;
  localparam int MP_W  = (LW > dld_pkg::DECAY_W) ? LW : dld_pkg::DECAY_W;
  localparam int ACC_W = MC_W + MP_W;
  localparam logic [LW-1:0] LEVEL_MAX = {{dld_pkg::SAMPLE_W{1'b1}}, {F{1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_GAIN1 = 5'b00010,
    S_GAIN2 = 5'b00100,
    S_STEP  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                         state_r;
  state_t                         state_nxt;
  logic [LW-1:0]                  level_r;
  logic [dld_pkg::SAMPLE_W-1:0]   prev_r;
  logic                           flag_r;
  logic [LW-1:0]                  mag_r;
  logic                           dir_r;
  logic                           out_valid_r;
  logic [dld_pkg::SAMPLE_W-1:0]   out_level_r;
  logic [dld_pkg::FINE_W-1:0]     out_fine_r;
  logic                           out_busy_r;

  logic                           acc_in;
  logic                           hold_hit;
  logic                           out_free;
  logic [LW-1:0]                  target;
  logic                           up;
  logic [LW-1:0]                  mag_in;
  logic                           mult_start;
  logic [MC_W-1:0]                mult_mc;
  logic [MP_W-1:0]                mult_mp;
  logic                           mult_done;
  logic [ACC_W-1:0]               prod;
  logic [dld_pkg::GAIN_W-1:0]     gain_sq;
  logic [LW-1:0]                  step;
  logic [LW:0]                    sum_up;
  logic [LW-1:0]                  apply_level;
  logic                           apply_flag;
  logic [dld_pkg::FINE_W-1:0]     fine_w;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc_in      = in_ch.valid && in_ch.ready;
  assign hold_hit    = cfg.hold_when_unchanged && (in_ch.sample == prev_r);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign target      = {in_ch.sample, {F{1'b0}}};
  assign up          = (target >= level_r);
  assign mag_in      = up ? (target - level_r) : (level_r - target);

  assign gain_sq = (cfg.curve_mode == dld_pkg::CURVE_HALF)
                 ? dld_pkg::GAIN_W'(prod >> dld_pkg::HALF_SHIFT)
                 : dld_pkg::GAIN_W'(prod >> dld_pkg::FULL_SHIFT);
  assign step    = LW'(prod >> dld_pkg::Q32_SHIFT);
  assign sum_up  = {1'b0, level_r} + {1'b0, step};

  always_comb begin
    if (dir_r) begin
      if (sum_up > {1'b0, LEVEL_MAX}) begin
        apply_level = LEVEL_MAX;
        apply_flag  = 1'b0;
      end else begin
        apply_level = sum_up[LW-1:0];
        apply_flag  = 1'b1;
      end
    end else begin
      if (step > level_r) begin
        apply_level = '0;
        apply_flag  = 1'b0;
      end else begin
        apply_level = level_r - step;
        apply_flag  = 1'b1;
      end
    end
  end

  generate
    if (F >= dld_pkg::FINE_FRAC) begin : g_fine_trunc
      assign fine_w = level_r[F+7:F-dld_pkg::FINE_FRAC];
    end else begin : g_fine_ext
      assign fine_w = {level_r, {(dld_pkg::FINE_FRAC-F){1'b0}}};
    end
  endgenerate

  always_comb begin
    state_nxt  = state_r;
    mult_start = 1'b0;
    mult_mc    = '0;
    mult_mp    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_ch.mode || hold_hit) begin
            state_nxt = S_DONE;
          end else begin
            mult_start = 1'b1;
            mult_mc    = MC_W'(cfg.decay_gain);
            mult_mp    = MP_W'(cfg.time_step);
            state_nxt  = S_GAIN1;
          end
        end
      end
      S_GAIN1: begin
        if (mult_done) begin
          mult_start = 1'b1;
          if (cfg.curve_mode == dld_pkg::CURVE_LIN) begin
            mult_mc   = MC_W'(prod[dld_pkg::GAIN_W-1:0]);
            mult_mp   = MP_W'(mag_r);
            state_nxt = S_STEP;
          end else begin
            mult_mc   = prod[MC_W-1:0];
            mult_mp   = MP_W'(cfg.decay_gain);
            state_nxt = S_GAIN2;
          end
        end
      end
      S_GAIN2: begin
        if (mult_done) begin
          mult_start = 1'b1;
          mult_mc    = MC_W'(gain_sq);
          mult_mp    = MP_W'(mag_r);
          state_nxt  = S_STEP;
        end
      end
      S_STEP: begin
        if (mult_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  dld_serial_mult #(
    .MC_W (MC_W),
    .MP_W (MP_W)
  ) u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mult_start),
    .mc_in   (mult_mc),
    .mp_in   (mult_mp),
    .done    (mult_done),
    .product (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      prev_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_in) begin
        prev_r <= in_ch.sample;
        if (in_ch.mode) begin
          level_r <= target;
        end else if (hold_hit) begin
          flag_r <= 1'b0;
        end
      end
      if ((state_r == S_STEP) && mult_done) begin
        level_r <= apply_level;
        flag_r  <= apply_flag;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      mag_r <= mag_in;
      dir_r <= up;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_level_r <= level_r[F+7:F];
      out_fine_r  <= fine_w;
      out_busy_r  <= flag_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.level_out  = out_level_r;
  assign out_ch.level_fine = out_fine_r;
  assign out_ch.busy_res   = out_busy_r;

`ifndef NO_ASSERTIONS
  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LEVEL_MAX)
    else $error("smoothed level above full scale");

  a_force_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_ch.mode) |=> (level_r == $past(target)))
    else $error("force request did not load the level");

  a_hold_keeps_level: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && !in_ch.mode && hold_hit) |=> (!flag_r && $stable(level_r)))
    else $error("held request changed the level or left the busy flag set");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented outside the completion state");
`endif

endmodule

`default_nettype wire

// ===== rtl/dmx_level_damper_unit.sv =====
// Exponential level damper for 8-bit light levels. Each request either forces the kept
// level to the sample (mode 1) or moves it toward the sample by a gain of decay*dt,
// decay*decay*dt/2 or decay*decay*dt depending on the curve register; the level is kept
// in Q8.FRACTION_BITS and returned as a byte, as Q8.16 and with a busy flag. Registers
// sit at byte addresses 0 (decay, Q1.16), 4 (dt, Q0.16), 8 (curve) and 12 (hold);
// out-of-range decay and dt writes are clamped; a curve above 2 selects curve 0. All
// products go through one radix-4 shift-add multiplier that retires two multiplier bits
// a cycle and ends early for small multipliers. A smoothing request runs the decay*dt
// product, the decay*decay*dt product unless curve 0 is set, and the step product;
// force and held requests skip the products. One request is in flight at a time, and
// the next one is accepted while the previous result waits in the output register.
`default_nettype none

module dmx_level_damper_unit #(
  parameter int FRACTION_BITS = dld_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dld_in_if.sink                                 in_ch,
  dld_out_if.source                              out_ch,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dld_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [dld_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [dld_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  dld_pkg::cfg_t cfg;

  dld_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dld_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
